// ===== rtl/core/lac_pkg.sv =====
package lac_pkg;

   // Field widths fixed by the channel format
   localparam int COLOR_BITS     = 8;
   localparam int OPACITY_BITS   = 7;
   localparam int LAYER_BITS     = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 7;

   // Register map
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OPACITY_BASE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INCLUDE_MASK = 3'd4;

   // Opacity is a percentage; larger register values saturate here
   localparam logic [OPACITY_BITS-1:0] OPACITY_FULL = 7'd100;

   // Blend weight scale = opacity * alpha, divided by 100 * 255
   localparam int SCALE_BITS = OPACITY_BITS + COLOR_BITS;
   localparam int DIVISOR    = 25500;
   localparam int DIV_BITS   = 15;

   // Queue between classifier and blend engine
   localparam int QPTR_BITS   = 1;
   localparam int QUEUE_DEPTH = 1 << QPTR_BITS;

   typedef logic [SCALE_BITS-1:0] scale_type;
   typedef logic [COLOR_BITS-1:0] color_type;

   typedef struct packed {
      logic      used;
      logic      last;
      scale_type scale;
      color_type red;
      color_type green;
      color_type blue;
   } entry_type;

endpackage

// ===== rtl/core/lac_front.sv =====
module lac_front #(
   parameter int LAYER_COUNT = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [lac_pkg::LAYER_BITS-1:0]       req_layer_number,
   input  logic [lac_pkg::COLOR_BITS-1:0]       req_in_red,
   input  logic [lac_pkg::COLOR_BITS-1:0]       req_in_green,
   input  logic [lac_pkg::COLOR_BITS-1:0]       req_in_blue,
   input  logic [lac_pkg::COLOR_BITS-1:0]       req_in_alpha,
   input  logic                                 req_last_layer,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [lac_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lac_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  logic                                 q_full,
   output logic                                 q_push,
   output lac_pkg::entry_type                   q_push_data
);

   logic [lac_pkg::OPACITY_BITS-1:0] opacity_ff [LAYER_COUNT];
   logic [lac_pkg::OPACITY_BITS-1:0] opacity_in [LAYER_COUNT];
   logic [LAYER_COUNT-1:0]           mask_ff;
   logic [LAYER_COUNT-1:0]           mask_in;
   logic                             csr_write;
   logic [lac_pkg::OPACITY_BITS-1:0] layer_opacity;
   logic [lac_pkg::OPACITY_BITS-1:0] clamped_opacity;
   logic                             layer_used;

   assign csr_write = csr_valid && csr_ready;

   // Decode register writes; indexes off the map are dropped
   always_comb begin
      for (int i = 0; i < LAYER_COUNT; i++) begin
         opacity_in[i] = opacity_ff[i];
         if (csr_write && csr_index == lac_pkg::CSR_OPACITY_BASE + 3'(i)) begin
            opacity_in[i] = csr_data[lac_pkg::OPACITY_BITS-1:0];
         end
      end
      mask_in = mask_ff;
      if (csr_write && csr_index == lac_pkg::CSR_INCLUDE_MASK) begin
         mask_in = csr_data[LAYER_COUNT-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAYER_COUNT; i++) begin
            opacity_ff[i] <= lac_pkg::OPACITY_FULL;
         end
         mask_ff <= '1;
      end else begin
         opacity_ff <= opacity_in;
         mask_ff    <= mask_in;
      end
   end

   // Look up the layer; layers past the configured count stay excluded
   always_comb begin
      layer_opacity = '0;
      layer_used    = 1'b0;
      for (int i = 0; i < LAYER_COUNT; i++) begin
         if (req_layer_number == lac_pkg::LAYER_BITS'(i)) begin
            layer_opacity = opacity_ff[i];
            layer_used    = mask_ff[i];
         end
      end
      clamped_opacity = (layer_opacity > lac_pkg::OPACITY_FULL) ?
                        lac_pkg::OPACITY_FULL : layer_opacity;
   end

   // Classify the beat and push it to the queue
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_push_data.used  = layer_used;
      q_push_data.last  = req_last_layer;
      q_push_data.scale = lac_pkg::SCALE_BITS'(clamped_opacity) *
                          lac_pkg::SCALE_BITS'(req_in_alpha);
      q_push_data.red   = req_in_red;
      q_push_data.green = req_in_green;
      q_push_data.blue  = req_in_blue;
   end

endmodule

// ===== rtl/core/lac_queue.sv =====
module lac_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lac_pkg::entry_type push_data,
   output logic               full,
   input  logic               pop,
   output lac_pkg::entry_type pop_data,
   output logic               empty
);

   lac_pkg::entry_type               slot_ff [lac_pkg::QUEUE_DEPTH];
   logic [lac_pkg::QPTR_BITS-1:0]    wr_ptr_ff;
   logic [lac_pkg::QPTR_BITS-1:0]    wr_ptr_in;
   logic [lac_pkg::QPTR_BITS-1:0]    rd_ptr_ff;
   logic [lac_pkg::QPTR_BITS-1:0]    rd_ptr_in;
   logic [lac_pkg::QPTR_BITS:0]      count_ff;
   logic [lac_pkg::QPTR_BITS:0]      count_in;

   assign full     = (count_ff == (lac_pkg::QPTR_BITS + 1)'(lac_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed beats
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue pop while empty");

endmodule

// ===== rtl/core/lac_blend.sv =====
module lac_blend #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  lac_pkg::entry_type             q_data,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lac_pkg::COLOR_BITS-1:0] rsp_out_red,
   output logic [lac_pkg::COLOR_BITS-1:0] rsp_out_green,
   output logic [lac_pkg::COLOR_BITS-1:0] rsp_out_blue,
   output logic [lac_pkg::COLOR_BITS-1:0] rsp_out_alpha
);

   // Coverage width, 1.0 included
   localparam int RW = FRACTION_BITS + 1;
   // First reciprocal step: split coverage by the divisor
   localparam int N1  = (RW > 16) ? RW : 16;
   localparam int S1  = N1 + lac_pkg::DIV_BITS;
   localparam int MW1 = N1 + 1;
   localparam int PW1 = N1 + MW1;
   localparam int QW1 = PW1 - S1;
   localparam longint unsigned M1 =
      ((64'd1 << S1) + lac_pkg::DIVISOR - 1) / lac_pkg::DIVISOR;
   // Second reciprocal step: remainder times scale by the divisor
   localparam int YW  = lac_pkg::DIV_BITS + lac_pkg::SCALE_BITS;
   localparam int S2  = YW + lac_pkg::DIV_BITS;
   localparam int MW2 = YW + 1;
   localparam int PW2 = YW + MW2;
   localparam longint unsigned M2 =
      ((64'd1 << S2) + lac_pkg::DIVISOR - 1) / lac_pkg::DIVISOR;
   localparam int QKW = QW1 + lac_pkg::SCALE_BITS;
   localparam int SW  = FRACTION_BITS + lac_pkg::COLOR_BITS;

   localparam logic [MW1-1:0] RECIP1 = MW1'(M1);
   localparam logic [MW2-1:0] RECIP2 = MW2'(M2);
   localparam logic [lac_pkg::DIV_BITS-1:0] DIV_VAL = lac_pkg::DIV_BITS'(lac_pkg::DIVISOR);
   localparam logic [RW-1:0] COVER_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_REMAIN = 6'b000010,
      ST_SCALE  = 6'b000100,
      ST_RECIP  = 6'b001000,
      ST_ACCUM  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type                        state_ff, state_in;
   lac_pkg::entry_type               cur_ff, cur_in;
   logic [RW-1:0]                    cover_ff, cover_in;
   logic [SW-1:0]                    sum_red_ff, sum_red_in;
   logic [SW-1:0]                    sum_green_ff, sum_green_in;
   logic [SW-1:0]                    sum_blue_ff, sum_blue_in;
   logic [PW1-1:0]                   prod1_ff, prod1_in;
   logic [QW1-1:0]                   q1_ff, q1_in;
   logic [lac_pkg::DIV_BITS-1:0]     rem_ff, rem_in;
   logic [YW-1:0]                    bk_ff, bk_in;
   logic [QKW-1:0]                   q1k_ff, q1k_in;
   logic [PW2-1:0]                   prod2_ff, prod2_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [lac_pkg::COLOR_BITS-1:0]   red_ff, red_in;
   logic [lac_pkg::COLOR_BITS-1:0]   green_ff, green_in;
   logic [lac_pkg::COLOR_BITS-1:0]   blue_ff, blue_in;
   logic [lac_pkg::COLOR_BITS-1:0]   alpha_ff, alpha_in;

   logic [N1-1:0]                    cover_ext;
   logic [QW1+lac_pkg::DIV_BITS-1:0] q1_times_d;
   logic [N1-1:0]                    rem_full;
   logic [RW-1:0]                    weight;
   logic [RW-1:0]                    covered;
   logic [RW+lac_pkg::COLOR_BITS-1:0] alpha_prod;
   logic                             out_free;

   assign cover_ext  = N1'(cover_ff);
   assign q1_times_d = (QW1 + lac_pkg::DIV_BITS)'(prod1_ff[PW1-1:S1]) *
                       (QW1 + lac_pkg::DIV_BITS)'(DIV_VAL);
   assign rem_full   = cover_ext - N1'(q1_times_d);
   assign weight     = RW'(q1k_ff) + RW'(prod2_ff[PW2-1:S2]);
   assign covered    = COVER_ONE - cover_ff;
   assign alpha_prod = {covered, {lac_pkg::COLOR_BITS{1'b0}}} -
                       (RW + lac_pkg::COLOR_BITS)'(covered);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign q_pop      = (state_ff == ST_IDLE) && !q_empty;

   // Sequence one sample through the weight computation
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      cover_in     = cover_ff;
      sum_red_in   = sum_red_ff;
      sum_green_in = sum_green_ff;
      sum_blue_in  = sum_blue_ff;
      prod1_in     = prod1_ff;
      q1_in        = q1_ff;
      rem_in       = rem_ff;
      bk_in        = bk_ff;
      q1k_in       = q1k_ff;
      prod2_in     = prod2_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      alpha_in     = alpha_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            // Coverage over divisor, by reciprocal
            prod1_in = PW1'(cover_ext) * PW1'(RECIP1);
            if (!q_empty) begin
               cur_in = q_data;
               if (q_data.used) begin
                  state_in = ST_REMAIN;
               end else if (q_data.last) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_REMAIN: begin
            q1_in    = prod1_ff[PW1-1:S1];
            rem_in   = rem_full[lac_pkg::DIV_BITS-1:0];
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            bk_in    = YW'(rem_ff) * YW'(cur_ff.scale);
            q1k_in   = QKW'(q1_ff) * QKW'(cur_ff.scale);
            state_in = ST_RECIP;
         end
         ST_RECIP: begin
            prod2_in = PW2'(bk_ff) * PW2'(RECIP2);
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            // Accumulate weighted color and drop coverage
            cover_in     = cover_ff - weight;
            sum_red_in   = sum_red_ff + SW'(weight) * SW'(cur_ff.red);
            sum_green_in = sum_green_ff + SW'(weight) * SW'(cur_ff.green);
            sum_blue_in  = sum_blue_ff + SW'(weight) * SW'(cur_ff.blue);
            state_in     = cur_ff.last ? ST_FINISH : ST_IDLE;
         end
         ST_FINISH: begin
            // Emit the pixel once the output register is free, then clear
            if (out_free) begin
               red_in       = sum_red_ff[FRACTION_BITS +: lac_pkg::COLOR_BITS];
               green_in     = sum_green_ff[FRACTION_BITS +: lac_pkg::COLOR_BITS];
               blue_in      = sum_blue_ff[FRACTION_BITS +: lac_pkg::COLOR_BITS];
               alpha_in     = alpha_prod[FRACTION_BITS +: lac_pkg::COLOR_BITS];
               rsp_valid_in = 1'b1;
               cover_in     = COVER_ONE;
               sum_red_in   = '0;
               sum_green_in = '0;
               sum_blue_in  = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cover_ff     <= COVER_ONE;
         sum_red_ff   <= '0;
         sum_green_ff <= '0;
         sum_blue_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cover_ff     <= cover_in;
         sum_red_ff   <= sum_red_in;
         sum_green_ff <= sum_green_in;
         sum_blue_ff  <= sum_blue_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      prod1_ff <= prod1_in;
      q1_ff    <= q1_in;
      rem_ff   <= rem_in;
      bk_ff    <= bk_in;
      q1k_ff   <= q1k_in;
      prod2_ff <= prod2_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
      alpha_ff <= alpha_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = red_ff;
   assign rsp_out_green = green_ff;
   assign rsp_out_blue  = blue_ff;
   assign rsp_out_alpha = alpha_ff;

   a_weight_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCUM) |-> (weight <= cover_ff))
      else $error("blend weight exceeds remaining coverage");

   a_cover_bound: assert property (@(posedge clock) disable iff (reset)
      cover_ff <= COVER_ONE)
      else $error("remaining coverage above one");

   a_remainder: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCALE) |-> (rem_ff < DIV_VAL))
      else $error("reciprocal remainder out of range");

   a_finish_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=>
         (cover_ff == COVER_ONE && sum_red_ff == '0 && rsp_valid_ff))
      else $error("pixel state not cleared after emit");

endmodule

// ===== rtl/core/layer_alpha_compositor.sv =====
// The blend engine takes one sample at a time: an included sample runs through the remain,
//    scale, reciprocal and accumulate states before the next is popped, and a pixel is emitted
//    in the finish state; the coverage feedback through the reciprocal multiply steps sets this.
// A 2-beat queue lets req keep being accepted, until it is full, while the engine or rsp is busy.
// Reset (synchronous, active high) clears the pixel state to full coverage and zero sums,
//    empties the queue, and sets every opacity to 100 and all include bits.
module layer_alpha_compositor #(
   parameter int LAYER_COUNT   = 4,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [lac_pkg::LAYER_BITS-1:0]       req_layer_number,
   input  logic [lac_pkg::COLOR_BITS-1:0]       req_in_red,
   input  logic [lac_pkg::COLOR_BITS-1:0]       req_in_green,
   input  logic [lac_pkg::COLOR_BITS-1:0]       req_in_blue,
   input  logic [lac_pkg::COLOR_BITS-1:0]       req_in_alpha,
   input  logic                                 req_last_layer,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [lac_pkg::COLOR_BITS-1:0]       rsp_out_red,
   output logic [lac_pkg::COLOR_BITS-1:0]       rsp_out_green,
   output logic [lac_pkg::COLOR_BITS-1:0]       rsp_out_blue,
   output logic [lac_pkg::COLOR_BITS-1:0]       rsp_out_alpha,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lac_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lac_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   logic               q_full;
   logic               q_empty;
   logic               q_push;
   logic               q_pop;
   lac_pkg::entry_type q_push_data;
   lac_pkg::entry_type q_pop_data;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   lac_front #(
      .LAYER_COUNT (LAYER_COUNT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_layer_number (req_layer_number),
      .req_in_red       (req_in_red),
      .req_in_green     (req_in_green),
      .req_in_blue      (req_in_blue),
      .req_in_alpha     (req_in_alpha),
      .req_last_layer   (req_last_layer),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_push_data      (q_push_data)
   );

   lac_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   lac_blend #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_blend (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_data        (q_pop_data),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_alpha (rsp_out_alpha)
   );

endmodule
